// File: rtl/fba_pkg.sv
// Shared types, constants and helpers for the frame bitmap allocator.
// Depends on nothing; frame_bitmap_allocator imports it.
package fba_pkg;

  localparam int FBA_WORD_BITS  = 32;
  localparam int FBA_INDEX_BITS = 10;
  localparam int FBA_BIT_BITS   = 5;
  localparam int FBA_WSEL_BITS  = FBA_INDEX_BITS - FBA_BIT_BITS;
  // Words that a frame index can reach.
  localparam int FBA_ADDR_WORDS = 1 << FBA_WSEL_BITS;
  localparam int FBA_NUM_WORDS  = 32;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_WAIT
  } st_t;

  typedef struct packed {
    logic                      found;
    logic [FBA_INDEX_BITS-1:0] free_index;
    logic                      bit_set;
  } result_t;

  typedef struct packed {
    logic                    hit;
    logic [FBA_BIT_BITS-1:0] pos;
  } zero_pos_t;

  // Position of the least significant zero bit of a 32-bit word.
  function automatic zero_pos_t first_zero32(input logic [FBA_WORD_BITS-1:0] w);
    zero_pos_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = FBA_WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.hit = 1'b1;
        r.pos = FBA_BIT_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/frame_bitmap_allocator.sv
// Frame bitmap allocator: one used/free bit per page frame held in a word RAM.
// Depends on fba_pkg and fba_ram.
//
// Each input beat carries a command in in_tuser and a frame number in in_tdata and produces
// exactly one output beat. Mark and clear set or reset the frame's bit, test reports it,
// and find returns the lowest free frame without marking it (found is 0 when none is free).
// Each request passes through the read-modify-write state. The RAM read is issued on the accepting
// edge; that state then modifies the word, writes it back and loads the result into the output
// register, or into a pending register while the output is still full. in_tready is low in that
// state and in the wait state, so a new request is taken only once the last one has left them.
// The word RAM's single read port with its registered read sets that limit. A further request is
// taken while a result waits in the output register; that request then holds off the input until
// the waiting beat leaves. Reset needs no clearing pass: per-word valid bits make an unwritten word
// read as all free, and per-word full flags let find pick its word at once.
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int NUM_WORDS = FBA_NUM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] frame_index, [15:10] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] bit_set, [10:1] free_index, [11] found, [15:12] zero
);

  // Words beyond what a frame index can name are never touched, so they are not stored.
  localparam int MEM_WORDS = (NUM_WORDS < FBA_ADDR_WORDS) ? NUM_WORDS : FBA_ADDR_WORDS;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  st_t                     state_r, state_nxt;
  cmd_t                    cmd_r;
  logic [AW-1:0]           wsel_r;
  logic [FBA_BIT_BITS-1:0] bit_r;
  logic                    in_range_r;
  logic                    any_free_r;
  logic [MEM_WORDS-1:0]    valid_r;
  logic [MEM_WORDS-1:0]    full_r;
  logic                    out_valid_r;
  result_t                 out_data_r;
  result_t                 pend_r;

  logic                     in_beat;
  logic                     out_free;
  logic [FBA_WSEL_BITS-1:0] in_word;
  logic                     in_range;
  logic [FBA_WORD_BITS-1:0] full_pad;
  zero_pos_t                word_pick;
  logic [AW-1:0]            rd_addr;
  logic [FBA_WORD_BITS-1:0] ram_rdata;
  logic [FBA_WORD_BITS-1:0] cur_word;
  logic [FBA_WORD_BITS-1:0] bit_mask;
  logic [FBA_WORD_BITS-1:0] new_word;
  zero_pos_t                bit_pick;
  logic                     ram_we;
  logic                     load_out;
  logic                     load_pend;
  result_t                  res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_word  = in_tdata[FBA_INDEX_BITS-1:FBA_BIT_BITS];
  assign in_range = 32'(in_word) < 32'(MEM_WORDS);

  // Lowest word that still has a free frame.
  always_comb begin
    full_pad                = '1;
    full_pad[MEM_WORDS-1:0] = full_r;
    word_pick               = first_zero32(full_pad);
  end

  always_comb begin
    if (cmd_t'(in_tuser) == CMD_FIND) begin
      rd_addr = word_pick.pos[AW-1:0];
    end else if (in_range) begin
      rd_addr = in_word[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  fba_ram #(
    .WIDTH (FBA_WORD_BITS),
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wsel_r),
    .wdata (new_word),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign cur_word = valid_r[wsel_r] ? ram_rdata : '0;
  assign bit_mask = FBA_WORD_BITS'(1) << bit_r;
  assign bit_pick = first_zero32(cur_word);

  always_comb begin
    case (cmd_r)
      CMD_MARK:  new_word = cur_word | bit_mask;
      CMD_CLEAR: new_word = cur_word & ~bit_mask;
      default:   new_word = cur_word;
    endcase
  end

  always_comb begin
    res = '0;
    case (cmd_r)
      CMD_TEST: res.bit_set = in_range_r && cur_word[bit_r];
      CMD_FIND: begin
        if (any_free_r) begin
          res.found      = 1'b1;
          res.free_index = {FBA_WSEL_BITS'(wsel_r), bit_pick.pos};
        end
      end
      default: res = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = out_free ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ram_we    = 1'b0;
    load_out  = 1'b0;
    load_pend = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_RMW: begin
        ram_we    = in_range_r && ((cmd_r == CMD_MARK) || (cmd_r == CMD_CLEAR));
        load_out  = out_free;
        load_pend = !out_free;
      end
      ST_WAIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        valid_r[wsel_r] <= 1'b1;
        full_r[wsel_r]  <= &new_word;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r      <= cmd_t'(in_tuser);
      wsel_r     <= rd_addr;
      bit_r      <= in_tdata[FBA_BIT_BITS-1:0];
      in_range_r <= in_range;
      any_free_r <= word_pick.hit;
    end
    if (load_pend) begin
      pend_r <= res;
    end
    if (load_out) begin
      out_data_r <= (state_r == ST_WAIT) ? pend_r : res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

  a_accept_to_rmw : assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_RMW))
    else $error("accepted beat did not enter read-modify-write");

  a_write_in_rmw : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_RMW) && in_range_r)
    else $error("bitmap write outside read-modify-write or out of range");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result overwrote an untaken output beat");

  a_find_word_not_full : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW) && (cmd_r == CMD_FIND) && any_free_r |-> bit_pick.hit)
    else $error("find picked a word with no free frame");

endmodule

// File: rtl/fba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
